// ===== rtl/srr_pkg.sv =====
`default_nettype none

package srr_pkg;

  localparam int NUM_TASKS   = 32;
  localparam int TID_W       = 6;
  localparam int AW          = $clog2(NUM_TASKS);
  localparam int LEN_W       = 16;
  localparam int RET_W       = 17;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS);
  localparam int CQ_DEPTH    = 2;
  localparam int CQ_AW       = $clog2(CQ_DEPTH);
  localparam int RQ_DEPTH    = 4;
  localparam int RQ_AW       = $clog2(RQ_DEPTH);

  localparam logic [TID_W-1:0] TID_NONE        = '1;
  localparam logic [RET_W-1:0] RET_BAD_PEER    = 17'h1FFFF;
  localparam logic [RET_W-1:0] RET_WRONG_STATE = 17'h1FFFE;

  typedef enum logic [2:0] {
    OP_SEND    = 3'd0,
    OP_RECV    = 3'd1,
    OP_REPLY   = 3'd2,
    OP_PEEK    = 3'd3,
    OP_CLEANUP = 3'd4,
    OP_CREATE  = 3'd5,
    OP_EXIT    = 3'd6
  } opcode_e;

  typedef enum logic [2:0] {
    ST_UNUSED   = 3'd0,
    ST_READY    = 3'd1,
    ST_SENDBLK  = 3'd2,
    ST_RECVBLK  = 3'd3,
    ST_REPLYBLK = 3'd4,
    ST_ZOMBIE   = 3'd5
  } status_e;

  typedef struct packed {
    opcode_e           op;
    logic [TID_W-1:0]  caller;
    logic [TID_W-1:0]  peer;
    logic [LEN_W-1:0]  msg_len;
    logic [LEN_W-1:0]  reply_len;
  } cmd_t;

  typedef struct packed {
    logic [TID_W-1:0]        target_tid;
    logic signed [RET_W-1:0] ret_value;
    logic                    has_sender;
    logic [TID_W-1:0]        sender_tid;
    logic                    make_ready;
    logic                    last;
  } res_t;

  typedef struct packed {
    status_e          st;
    logic [TID_W-1:0] head;
    logic [TID_W-1:0] tail;
  } row_t;

  localparam int   ROW_W     = $bits(row_t);
  localparam row_t ROW_RESET = '{st: ST_UNUSED, head: TID_NONE, tail: TID_NONE};

  function automatic logic tid_ok(input logic [TID_W-1:0] t);
    return t < TID_W'(NUM_TASKS);
  endfunction

  function automatic logic [RET_W-1:0] min_len(input logic [LEN_W-1:0] a,
                                              input logic [LEN_W-1:0] b);
    return {1'b0, (a < b) ? a : b};
  endfunction

  function automatic res_t mk_res(input logic [TID_W-1:0] target,
                                  input logic [RET_W-1:0] ret,
                                  input logic             has_snd,
                                  input logic [TID_W-1:0] snd,
                                  input logic             rdy,
                                  input logic             lst);
    res_t r;
    r.target_tid = target;
    r.ret_value  = ret;
    r.has_sender = has_snd;
    r.sender_tid = snd;
    r.make_ready = rdy;
    r.last       = lst;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/srr_ram.sv =====
`default_nettype none

module srr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/srr_front.sv =====
`default_nettype none

module srr_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [2:0]                opcode_i,
  input  logic [srr_pkg::TID_W-1:0] caller_tid_i,
  input  logic [srr_pkg::TID_W-1:0] peer_tid_i,
  input  logic [srr_pkg::LEN_W-1:0] msg_len_i,
  input  logic [srr_pkg::LEN_W-1:0] reply_buf_len_i,
  output logic                      cmd_valid_o,
  output srr_pkg::cmd_t             cmd_o,
  input  logic                      cmd_pop_i
);
  import srr_pkg::*;

  cmd_t             mem_q [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CQ_AW:0]   cnt_q;
  logic             accept, keep, wr, rd;
  cmd_t             cmd_in;

  // ignored calls are dropped here
  assign keep   = tid_ok(caller_tid_i) && (opcode_i <= 3'(OP_EXIT));
  assign accept = push && !full;
  assign wr     = accept && keep;
  assign rd     = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cmd_in.op        = opcode_e'(opcode_i);
    cmd_in.caller    = caller_tid_i;
    cmd_in.peer      = peer_tid_i;
    cmd_in.msg_len   = msg_len_i;
    cmd_in.reply_len = reply_buf_len_i;
  end

  assign full        = (cnt_q == (CQ_AW+1)'(CQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + (CQ_AW+1)'(wr) - (CQ_AW+1)'(rd);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srr_outq.sv =====
`default_nettype none

module srr_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  srr_pkg::res_t res_i,
  output logic          full_o,
  input  logic          pop,
  output logic          empty,
  output srr_pkg::res_t res_o
);
  import srr_pkg::*;

  res_t             mem_q [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [RQ_AW:0]   cnt_q;
  logic             wr, rd;

  assign full_o = (cnt_q == (RQ_AW+1)'(RQ_DEPTH));
  assign empty  = (cnt_q == '0);
  assign wr     = push_i && !full_o;
  assign rd     = pop && !empty;
  assign res_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + (RQ_AW+1)'(wr) - (RQ_AW+1)'(rd);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srr_back.sv =====
`default_nettype none

module srr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  srr_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output srr_pkg::res_t res_o
);
  import srr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LD_C, S_LD_P, S_EXEC, S_POP_RD, S_POP_LD, S_WB, S_EMIT
  } state_e;

  state_e           state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  row_t             crow_q, crow_d, xrow_q, xrow_d;
  logic [AW-1:0]    xa_q, xa_d, lnka_q, lnka_d;
  logic [LEN_W-1:0] slp_q, slp_d, rcp_q, rcp_d, vcp_q, vcp_d;
  logic             wc_q, wc_d, wx_q, wx_d, link_q, link_d, loop_q, loop_d;
  logic [1:0]       nres_q, nres_d;
  res_t             res_q, res_d, res2_q, res2_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_TASKS-1:0] row_vld_q;
  logic             rvld_q;

  logic [AW-1:0]    c_a, p_a, row_raddr, len_raddr, row_waddr, nxt_waddr;
  logic             row_we, sl_we, rc_we, vc_we, nxt_we;
  row_t             row_wdata, row_rd;
  logic [ROW_W-1:0] row_rdata;
  logic [TID_W-1:0] nxt_wdata, nxt_rdata;
  logic [LEN_W-1:0] sl_rdata, rc_rdata, vc_rdata;

  assign c_a    = cmd_q.caller[AW-1:0];
  assign p_a    = cmd_q.peer[AW-1:0];
  assign row_rd = rvld_q ? row_t'(row_rdata) : ROW_RESET;

  srr_ram #(.WIDTH(ROW_W), .DEPTH(NUM_TASKS)) u_row (
    .clk_i, .we_i(row_we), .waddr_i(row_waddr), .wdata_i(row_wdata),
    .raddr_i(row_raddr), .rdata_o(row_rdata));
  srr_ram #(.WIDTH(LEN_W), .DEPTH(NUM_TASKS)) u_sl (
    .clk_i, .we_i(sl_we), .waddr_i(c_a), .wdata_i(cmd_q.msg_len),
    .raddr_i(len_raddr), .rdata_o(sl_rdata));
  srr_ram #(.WIDTH(LEN_W), .DEPTH(NUM_TASKS)) u_rc (
    .clk_i, .we_i(rc_we), .waddr_i(c_a), .wdata_i(cmd_q.reply_len),
    .raddr_i(len_raddr), .rdata_o(rc_rdata));
  srr_ram #(.WIDTH(LEN_W), .DEPTH(NUM_TASKS)) u_vc (
    .clk_i, .we_i(vc_we), .waddr_i(c_a), .wdata_i(cmd_q.msg_len),
    .raddr_i(len_raddr), .rdata_o(vc_rdata));
  srr_ram #(.WIDTH(TID_W), .DEPTH(NUM_TASKS)) u_nxt (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_waddr), .wdata_i(nxt_wdata),
    .raddr_i(crow_q.head[AW-1:0]), .rdata_o(nxt_rdata));

  always_comb begin
    unique case (state_q)
      S_IDLE: begin
        row_raddr = cmd_i.caller[AW-1:0];
        len_raddr = cmd_i.peer[AW-1:0];
      end
      S_POP_RD: begin
        row_raddr = crow_q.head[AW-1:0];
        len_raddr = crow_q.head[AW-1:0];
      end
      default: begin
        row_raddr = p_a;
        len_raddr = p_a;
      end
    endcase
  end

  always_comb begin
    row_t             t;
    row_t             hrow;
    logic             rdy, conn, lastb;
    logic [RET_W-1:0] len;

    state_d = state_q;
    cmd_d   = cmd_q;
    crow_d  = crow_q;
    xrow_d  = xrow_q;
    xa_d    = xa_q;
    lnka_d  = lnka_q;
    slp_d   = slp_q;
    rcp_d   = rcp_q;
    vcp_d   = vcp_q;
    wc_d    = wc_q;
    wx_d    = wx_q;
    link_d  = link_q;
    loop_d  = loop_q;
    nres_d  = nres_q;
    res_d   = res_q;
    res2_d  = res2_q;
    cnt_d   = cnt_q;

    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = res_q;
    row_we     = 1'b0;
    row_waddr  = c_a;
    row_wdata  = crow_q;
    sl_we      = 1'b0;
    rc_we      = 1'b0;
    vc_we      = 1'b0;
    nxt_we     = 1'b0;
    nxt_waddr  = c_a;
    nxt_wdata  = TID_NONE;

    rdy   = (crow_q.st == ST_READY);
    conn  = tid_ok(cmd_q.peer) && (xrow_q.st != ST_UNUSED) && (xrow_q.st != ST_ZOMBIE);
    t     = (cmd_q.peer == cmd_q.caller) ? crow_q : xrow_q;
    hrow  = row_rd;
    lastb = 1'b1;
    len   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          state_d   = S_LD_C;
        end
      end
      S_LD_C: begin
        crow_d  = row_rd;
        slp_d   = sl_rdata;
        rcp_d   = rc_rdata;
        vcp_d   = vc_rdata;
        state_d = S_LD_P;
      end
      S_LD_P: begin
        xrow_d  = row_rd;
        xa_d    = p_a;
        wc_d    = 1'b0;
        wx_d    = 1'b0;
        link_d  = 1'b0;
        loop_d  = 1'b0;
        nres_d  = '0;
        cnt_d   = '0;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_WB;
        unique case (cmd_q.op)
          OP_SEND: begin
            if (rdy) begin
              if (!conn) begin
                res_d  = mk_res(cmd_q.caller, RET_BAD_PEER, 1'b0, '0, 1'b0, 1'b1);
                nres_d = 2'd1;
              end else begin
                sl_we = 1'b1;
                rc_we = 1'b1;
                if (xrow_q.st == ST_SENDBLK) begin
                  res_d = mk_res(cmd_q.peer, min_len(vcp_q, cmd_q.msg_len), 1'b1,
                                 cmd_q.caller, 1'b1, 1'b1);
                  nres_d    = 2'd1;
                  crow_d.st = ST_REPLYBLK;
                  xrow_d.st = ST_READY;
                  wc_d      = 1'b1;
                  wx_d      = 1'b1;
                end else begin
                  nxt_we = 1'b1;
                  if (!tid_ok(t.head)) begin
                    t.head = cmd_q.caller;
                  end else if (tid_ok(t.tail)) begin
                    link_d = 1'b1;
                    lnka_d = t.tail[AW-1:0];
                  end
                  t.tail = cmd_q.caller;
                  if (cmd_q.peer == cmd_q.caller) begin
                    t.st   = ST_RECVBLK;
                    crow_d = t;
                  end else begin
                    xrow_d    = t;
                    wx_d      = 1'b1;
                    crow_d.st = ST_RECVBLK;
                  end
                  wc_d = 1'b1;
                end
              end
            end
          end
          OP_RECV: begin
            if (rdy) begin
              vc_we = 1'b1;
              if (tid_ok(crow_q.head)) begin
                state_d = S_POP_RD;
              end else begin
                crow_d.st = ST_SENDBLK;
                wc_d      = 1'b1;
              end
            end
          end
          OP_REPLY, OP_PEEK: begin
            if (rdy) begin
              nres_d = 2'd1;
              if (!conn) begin
                res_d = mk_res(cmd_q.caller, RET_BAD_PEER, 1'b0, '0, 1'b0, 1'b1);
              end else if (xrow_q.st != ST_REPLYBLK) begin
                res_d = mk_res(cmd_q.caller, RET_WRONG_STATE, 1'b0, '0, 1'b0, 1'b1);
              end else if (cmd_q.op == OP_PEEK) begin
                res_d = mk_res(cmd_q.caller, min_len(slp_q, cmd_q.msg_len), 1'b0, '0,
                               1'b0, 1'b1);
              end else begin
                len       = min_len(rcp_q, cmd_q.reply_len);
                res_d     = mk_res(cmd_q.peer, len, 1'b0, '0, 1'b1, 1'b0);
                res2_d    = mk_res(cmd_q.caller, len, 1'b0, '0, 1'b0, 1'b1);
                nres_d    = 2'd2;
                xrow_d.st = ST_READY;
                wx_d      = 1'b1;
              end
            end
          end
          OP_CLEANUP: begin
            if (tid_ok(crow_q.head)) begin
              state_d = S_POP_RD;
            end
          end
          OP_CREATE: begin
            if (crow_q.st == ST_UNUSED || crow_q.st == ST_ZOMBIE) begin
              crow_d.st = ST_READY;
              wc_d      = 1'b1;
            end
          end
          OP_EXIT: begin
            if (rdy) begin
              crow_d.st = ST_ZOMBIE;
              wc_d      = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_POP_RD: begin
        state_d = S_POP_LD;
      end
      S_POP_LD: begin
        t = crow_q;
        if (tid_ok(nxt_rdata)) begin
          t.head = nxt_rdata;
        end else begin
          t.head = TID_NONE;
          t.tail = TID_NONE;
        end
        if (cmd_q.op == OP_RECV) begin
          hrow.st = ST_REPLYBLK;
          res_d   = mk_res(cmd_q.caller, min_len(cmd_q.msg_len, sl_rdata), 1'b1,
                           crow_q.head, 1'b0, 1'b1);
          loop_d  = 1'b0;
        end else begin
          lastb   = !tid_ok(nxt_rdata) || (cnt_q == CNT_W'(MAX_RESULTS - 1));
          hrow.st = ST_READY;
          res_d   = mk_res(crow_q.head, RET_WRONG_STATE, 1'b0, '0, 1'b1, lastb);
          loop_d  = !lastb;
          cnt_d   = cnt_q + 1'b1;
        end
        if (crow_q.head == cmd_q.caller) begin
          t.st = hrow.st;
          wx_d = 1'b0;
        end else begin
          xrow_d = hrow;
          xa_d   = crow_q.head[AW-1:0];
          wx_d   = 1'b1;
        end
        crow_d  = t;
        wc_d    = 1'b1;
        nres_d  = 2'd1;
        state_d = S_WB;
      end
      S_WB: begin
        priority if (link_q) begin
          nxt_we    = 1'b1;
          nxt_waddr = lnka_q;
          nxt_wdata = cmd_q.caller;
          link_d    = 1'b0;
        end else if (wx_q) begin
          row_we    = 1'b1;
          row_waddr = xa_q;
          row_wdata = xrow_q;
          wx_d      = 1'b0;
        end else if (wc_q) begin
          row_we = 1'b1;
          wc_d   = 1'b0;
        end else if (nres_q != '0) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (nres_q == 2'd2) begin
            res_d  = res2_q;
            nres_d = 2'd1;
          end else begin
            nres_d  = '0;
            state_d = loop_q ? S_POP_RD : S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    crow_q <= crow_d;
    xrow_q <= xrow_d;
    xa_q   <= xa_d;
    lnka_q <= lnka_d;
    slp_q  <= slp_d;
    rcp_q  <= rcp_d;
    vcp_q  <= vcp_d;
    res_q  <= res_d;
    res2_q <= res2_d;
    cnt_q  <= cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wc_q      <= 1'b0;
      wx_q      <= 1'b0;
      link_q    <= 1'b0;
      loop_q    <= 1'b0;
      nres_q    <= '0;
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      wc_q    <= wc_d;
      wx_q    <= wx_d;
      link_q  <= link_d;
      loop_q  <= loop_d;
      nres_q  <= nres_d;
      if (row_we) begin
        row_vld_q[row_waddr] <= 1'b1;
      end
      rvld_q <= ({1'b0, row_raddr} < (AW+1)'(NUM_TASKS)) ? row_vld_q[row_raddr] : 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/send_receive_reply_ipc_engine_top.sv =====
`default_nettype none

// Channel   Handshake      Payload
// call      push / full    opcode_i caller_tid_i peer_tid_i msg_len_i reply_buf_len_i
// return    pop / empty    target_tid_o ret_value_o has_sender_o sender_tid_o
//                          make_ready_o last_o
// A call runs through the sequencer in order: two table read steps, an execute step,
// a write-back step per table write, a closing step, then one emit per result, held
// while the return queue is full. Every table sits behind one RAM read port.
// Receive adds the queue pop steps; cleanup repeats pop, write-back and emit per sender.
// Reset clears the task table by per-row valid bits, no clearing pass.
// A full return queue stalls the sequencer only; the call queue keeps taking items until full.

module send_receive_reply_ipc_engine_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic [2:0]                       opcode_i,
  input  logic [srr_pkg::TID_W-1:0]        caller_tid_i,
  input  logic [srr_pkg::TID_W-1:0]        peer_tid_i,
  input  logic [srr_pkg::LEN_W-1:0]        msg_len_i,
  input  logic [srr_pkg::LEN_W-1:0]        reply_buf_len_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [srr_pkg::TID_W-1:0]        target_tid_o,
  output logic signed [srr_pkg::RET_W-1:0] ret_value_o,
  output logic                             has_sender_o,
  output logic [srr_pkg::TID_W-1:0]        sender_tid_o,
  output logic                             make_ready_o,
  output logic                             last_o
);
  import srr_pkg::*;

  logic cmd_valid, cmd_pop, res_full, res_push;
  cmd_t cmd;
  res_t res_in, res_out;

  srr_front u_front (
    .clk_i, .rst_ni, .push, .full, .opcode_i, .caller_tid_i, .peer_tid_i,
    .msg_len_i, .reply_buf_len_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop));

  srr_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .res_full_i(res_full), .res_push_o(res_push), .res_o(res_in));

  srr_outq u_outq (
    .clk_i, .rst_ni, .push_i(res_push), .res_i(res_in), .full_o(res_full),
    .pop, .empty, .res_o(res_out));

  assign target_tid_o = res_out.target_tid;
  assign ret_value_o  = res_out.ret_value;
  assign has_sender_o = res_out.has_sender;
  assign sender_tid_o = res_out.sender_tid;
  assign make_ready_o = res_out.make_ready;
  assign last_o       = res_out.last;

  a_no_res_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_push && res_full))
    else $error("result pushed into full return queue");

  a_no_cmd_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_pop && !cmd_valid))
    else $error("sequencer took an item from empty call queue");

  a_empty_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> $past(res_push))
    else $error("return queue filled without a result push");

endmodule

`default_nettype wire

// ===== test/send_receive_reply_ipc_engine_top_tb.sv =====
`timescale 1ns / 1ps

module send_receive_reply_ipc_engine_top_tb;
  import srr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;

  typedef struct packed {
    logic [5:0]  tgt;
    logic [16:0] ret;
    logic        hs;
    logic [5:0]  snd;
    logic        rdy;
    logic        lst;
  } ret_rec_t;

  typedef struct {
    opcode_e     op;
    logic [5:0]  caller;
    logic [5:0]  peer;
    logic [15:0] mlen;
    logic [15:0] rlen;
    bit          typed;
    ret_rec_t    exp_ret;
  } call_row_t;

  logic clk_i, rst_ni;
  logic push, full, empty, pop;
  logic [2:0]  opcode_i;
  logic [5:0]  caller_tid_i, peer_tid_i;
  logic [15:0] msg_len_i, reply_buf_len_i;
  logic [5:0]  target_tid_o, sender_tid_o;
  logic signed [16:0] ret_value_o;
  logic has_sender_o, make_ready_o, last_o;

  send_receive_reply_ipc_engine_top dut (.*);

  status_e     t_status [64];
  logic [15:0] t_slen [64], t_rcap [64], t_recv [64];
  logic [5:0]  q_head [64], q_tail [64], q_next [64];

  ret_rec_t pending_returns[$];
  ret_rec_t step_out[$];
  int errors = 0;
  int idle_cnt = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit live(logic [5:0] t);
    return t < NUM_TASKS && t_status[t] != ST_UNUSED && t_status[t] != ST_ZOMBIE;
  endfunction

  function automatic logic [16:0] shorter(logic [15:0] a, logic [15:0] b);
    return {1'b0, (a < b) ? a : b};
  endfunction

  function automatic void add_ret(logic [5:0] t, logic [16:0] r, logic hs,
                                  logic [5:0] s, logic rd);
    step_out.push_back('{tgt: t, ret: r, hs: hs, snd: s, rdy: rd, lst: 1'b0});
  endfunction

  function automatic logic [5:0] dequeue_sender(logic [5:0] q);
    logic [5:0] h;
    h = q_head[q];
    if (h >= NUM_TASKS) return TID_NONE;
    q_head[q] = q_next[h];
    if (q_head[q] >= NUM_TASKS) begin
      q_head[q] = TID_NONE;
      q_tail[q] = TID_NONE;
    end
    return h;
  endfunction

  function automatic void predict_call(opcode_e op, logic [5:0] c, logic [5:0] p,
                                       logic [15:0] ml, logic [15:0] rl);
    logic [5:0] s;
    logic [16:0] len;
    step_out.delete();
    if (c >= NUM_TASKS) return;
    if ((op <= OP_PEEK || op == OP_EXIT) && t_status[c] != ST_READY) return;
    case (op)
      OP_SEND: begin
        if (!live(p)) add_ret(c, RET_BAD_PEER, 0, 0, 0);
        else begin
          t_slen[c] = ml;
          t_rcap[c] = rl;
          if (t_status[p] == ST_SENDBLK) begin
            add_ret(p, shorter(t_recv[p], ml), 1, c, 1);
            t_status[c] = ST_REPLYBLK;
            t_status[p] = ST_READY;
          end else begin
            q_next[c] = TID_NONE;
            if (q_head[p] >= NUM_TASKS) q_head[p] = c;
            else if (q_tail[p] < NUM_TASKS) q_next[q_tail[p]] = c;
            q_tail[p] = c;
            t_status[c] = ST_RECVBLK;
          end
        end
      end
      OP_RECV: begin
        t_recv[c] = ml;
        s = dequeue_sender(c);
        if (s < NUM_TASKS) begin
          add_ret(c, shorter(ml, t_slen[s]), 1, s, 0);
          t_status[s] = ST_REPLYBLK;
        end else t_status[c] = ST_SENDBLK;
      end
      OP_REPLY, OP_PEEK: begin
        if (!live(p)) add_ret(c, RET_BAD_PEER, 0, 0, 0);
        else if (t_status[p] != ST_REPLYBLK) add_ret(c, RET_WRONG_STATE, 0, 0, 0);
        else if (op == OP_PEEK) add_ret(c, shorter(t_slen[p], ml), 0, 0, 0);
        else begin
          len = shorter(t_rcap[p], rl);
          add_ret(p, len, 0, 0, 1);
          add_ret(c, len, 0, 0, 0);
          t_status[p] = ST_READY;
        end
      end
      OP_CLEANUP: begin
        while (step_out.size() < MAX_RESULTS) begin
          s = dequeue_sender(c);
          if (s >= NUM_TASKS) break;
          t_status[s] = ST_READY;
          add_ret(s, RET_WRONG_STATE, 0, 0, 1);
        end
      end
      OP_CREATE:
        if (t_status[c] == ST_UNUSED || t_status[c] == ST_ZOMBIE) t_status[c] = ST_READY;
      OP_EXIT: t_status[c] = ST_ZOMBIE;
      default: ;
    endcase
    if (step_out.size() > 0) step_out[step_out.size()-1].lst = 1'b1;
  endfunction

  task automatic issue_call(logic [2:0] op, logic [5:0] c, logic [5:0] p,
                            logic [15:0] ml, logic [15:0] rl,
                            bit typed = 0, ret_rec_t exp_ret = '0);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    opcode_i <= op;
    caller_tid_i <= c;
    peer_tid_i <= p;
    msg_len_i <= ml;
    reply_buf_len_i <= rl;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_call(opcode_e'(op), c, p, ml, rl);
    if (typed && (step_out.size() != 1 || step_out[0] != exp_ret)) begin
      $error("typed row: expected %p", exp_ret);
      errors++;
    end
    foreach (step_out[i]) pending_returns.push_back(step_out[i]);
  endtask

  task automatic drain_returns();
    push <= 1'b0;
    while (pending_returns.size() > 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    ret_rec_t e;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (pending_returns.size() == 0) begin
          $error("unexpected result target_tid=%0d", target_tid_o);
          errors++;
        end else begin
          e = pending_returns.pop_front();
          if (target_tid_o !== e.tgt) begin
            $error("target_tid exp %0d got %0d", e.tgt, target_tid_o); errors++;
          end
          if (ret_value_o !== e.ret) begin
            $error("ret_value exp %0h got %0h", e.ret, ret_value_o); errors++;
          end
          if (has_sender_o !== e.hs) begin
            $error("has_sender exp %0d got %0d", e.hs, has_sender_o); errors++;
          end
          if (sender_tid_o !== e.snd) begin
            $error("sender_tid exp %0d got %0d", e.snd, sender_tid_o); errors++;
          end
          if (make_ready_o !== e.rdy) begin
            $error("make_ready exp %0d got %0d", e.rdy, make_ready_o); errors++;
          end
          if (last_o !== e.lst) begin
            $error("last exp %0d got %0d", e.lst, last_o); errors++;
          end
        end
      end
      pop <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
      if ((push && !full) || (pop && !empty)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // pick mostly valid task ids from a small pool so rendezvous actually happen
  function automatic logic [5:0] pick_tid();
    int r;
    r = $urandom_range(99);
    if (r < 85) return 6'($urandom_range(7));
    if (r < 95) return 6'($urandom_range(NUM_TASKS - 1));
    return 6'($urandom_range(63));
  endfunction

  function automatic logic [15:0] pick_len();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  call_row_t directed [] = '{
    '{OP_SEND,    6'd0,  6'd1,  16'd5,    16'd5,    0, '0},
    '{OP_CREATE,  6'd0,  6'd0,  16'd0,    16'd0,    0, '0},
    '{OP_CREATE,  6'd1,  6'd0,  16'd0,    16'd0,    0, '0},
    '{OP_CREATE,  6'd2,  6'd0,  16'd0,    16'd0,    0, '0},
    '{OP_CREATE,  6'd31, 6'd0,  16'd0,    16'd0,    0, '0},
    '{OP_CREATE,  6'd63, 6'd0,  16'd0,    16'd0,    0, '0},
    '{OP_SEND,    6'd0,  6'd63, 16'hFFFF, 16'hFFFF, 1,
      '{6'd0, RET_BAD_PEER, 0, 6'd0, 0, 1}},
    '{OP_PEEK,    6'd0,  6'd5,  16'd1,    16'd1,    1,
      '{6'd0, RET_BAD_PEER, 0, 6'd0, 0, 1}},
    '{OP_REPLY,   6'd0,  6'd1,  16'd1,    16'd1,    1,
      '{6'd0, RET_WRONG_STATE, 0, 6'd0, 0, 1}},
    '{OP_RECV,    6'd1,  6'd0,  16'hFFFF, 16'd0,    0, '0},
    '{OP_SEND,    6'd0,  6'd1,  16'hFFFF, 16'hFFFF, 0, '0},
    '{OP_PEEK,    6'd31, 6'd0,  16'h1234, 16'd0,    0, '0},
    '{OP_REPLY,   6'd1,  6'd0,  16'd0,    16'h8000, 0, '0},
    '{OP_SEND,    6'd0,  6'd2,  16'h00FF, 16'h0000, 0, '0},
    '{OP_SEND,    6'd1,  6'd2,  16'h0000, 16'hFFFF, 0, '0},
    '{OP_SEND,    6'd31, 6'd2,  16'h5555, 16'hAAAA, 0, '0},
    '{OP_SEND,    6'd0,  6'd2,  16'd7,    16'd7,    0, '0},
    '{OP_RECV,    6'd2,  6'd0,  16'h0010, 16'd0,    0, '0},
    '{OP_CLEANUP, 6'd2,  6'd0,  16'd0,    16'd0,    0, '0},
    '{OP_REPLY,   6'd2,  6'd0,  16'd0,    16'h0004, 0, '0},
    '{OP_EXIT,    6'd2,  6'd0,  16'd0,    16'd0,    0, '0},
    '{OP_SEND,    6'd0,  6'd2,  16'd3,    16'd3,    1,
      '{6'd0, RET_BAD_PEER, 0, 6'd0, 0, 1}},
    '{OP_CREATE,  6'd2,  6'd0,  16'd0,    16'd0,    0, '0},
    '{OP_CLEANUP, 6'd2,  6'd0,  16'd0,    16'd0,    0, '0},
    '{opcode_e'(3'd7), 6'd0, 6'd1, 16'd9, 16'd9,    0, '0}
  };

  task automatic random_calls(int n);
    int k;
    logic [2:0] op;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4: op = OP_SEND;
        5, 6, 7, 8:    op = OP_RECV;
        9, 10, 11, 12: op = OP_REPLY;
        13, 14:        op = OP_PEEK;
        15:            op = OP_CLEANUP;
        16, 17:        op = OP_CREATE;
        18:            op = OP_EXIT;
        default:       op = 3'd7;
      endcase
      issue_call(op, pick_tid(), pick_tid(), pick_len(), pick_len());
    end
  endtask

  initial begin
    int i;
    logic [5:0] t;
    foreach (t_status[j]) begin
      t_status[j] = ST_UNUSED;
      t_slen[j] = '0; t_rcap[j] = '0; t_recv[j] = '0;
      q_head[j] = TID_NONE; q_tail[j] = TID_NONE; q_next[j] = TID_NONE;
    end
    rst_ni = 1'b0;
    push = 1'b0; pop = 1'b0;
    opcode_i = '0; caller_tid_i = '0; peer_tid_i = '0;
    msg_len_i = '0; reply_buf_len_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 23; recv_idle_pct = 52;
    for (i = 0; i < directed.size(); i++)
      issue_call(directed[i].op, directed[i].caller, directed[i].peer,
                 directed[i].mlen, directed[i].rlen, directed[i].typed, directed[i].exp_ret);
    drain_returns();

    // long queue: 31 senders then one cleanup
    for (t = 0; t < NUM_TASKS; t++) issue_call(OP_CREATE, t, 6'd0, 16'd0, 16'd0);
    for (t = 1; t < NUM_TASKS; t++)
      issue_call(OP_SEND, t, 6'd0, 16'($urandom), 16'($urandom));
    issue_call(OP_CLEANUP, 6'd0, 6'd0, 16'd0, 16'd0);
    drain_returns();

    random_calls(30);
    send_idle_pct = 52; recv_idle_pct = 23;
    random_calls(30);
    drain_returns();
    send_idle_pct = 0; recv_idle_pct = 0;
    random_calls(30);

    drain_returns();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_returns.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
